// ===== design/mcpit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpit_pkg
// Types and constants shared by the poll interval timer modules.
// ----------------------------------------------------------------------------
package mcpit_pkg;

	localparam int NUM_CHANNELS_DEF = 8;
	localparam int MAX_RESULTS      = 8;
	localparam int OUT_DEPTH        = 2 * MAX_RESULTS;
	localparam int CH_FIELD_W       = 6;

	localparam logic [7:0] COUNT_MAX     = 8'hFF;
	localparam logic [7:0] MIN_IVL_RESET = 8'd1;

	localparam logic [1:0] MODE_TICK       = 2'd0;
	localparam logic [1:0] MODE_LEGACY_SET = 2'd1;
	localparam logic [1:0] MODE_SET        = 2'd2;
	localparam logic [1:0] MODE_REQUEST    = 2'd3;

	localparam logic CFG_MIN_INTERVAL   = 1'b0;
	localparam logic CFG_LEGACY_CHANNEL = 1'b1;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_REQ  = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] service;
		logic [7:0] max_ivl;
		logic       link_up;
	} in_word_t;

	typedef struct packed {
		logic [2:0] poll_channel;
		logic       last;
	} out_word_t;

	typedef struct packed {
		logic [1:0]            op;
		logic [CH_FIELD_W-1:0] ch;
		logic [7:0]            ivl;
		logic                  link;
	} cmd_t;

	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} cmd_chan_t;

endpackage

// ===== design/multi_channel_poll_interval_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_channel_poll_interval_timer
// Per-channel minute counters that raise polls between a minimum and a
// maximum interval.
//
// Input words are pushed with push while full is low. A word is a minute
// tick, a set-interval (plain or legacy) or a poll request. Results are
// poll words, read while empty is low and taken with pop; the final poll
// caused by one input word carries last. Configuration (min_interval,
// legacy_channel) is written on the cfg channel, which is always ready.
// A two-entry command queue sits between the input side and the engine.
// The engine takes one command at a time: a set or a tick while stopped
// is done in ST_IDLE, a request goes through ST_REQ, and a running tick
// walks the channels in ST_WALK, one channel per cycle from the counter
// and interval RAMs, then ends in ST_FLUSH. A request's poll is written
// from ST_REQ; a tick's polls are written during the walk, each held
// until the next one fires; the last comes from ST_FLUSH. The engine starts a
// command only with room for a full burst of results in the result queue,
// so a stalled receiver backs up into the command queue and raises full.
// Reset clears all counters and intervals and leaves the timer stopped,
// with min_interval 1 and legacy_channel 0; no clearing pass is needed.
// ----------------------------------------------------------------------------
module multi_channel_poll_interval_timer #(
	parameter int NUM_CHANNELS = mcpit_pkg::NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  mcpit_pkg::in_word_t  item,
	output logic                 empty,
	input  logic                 pop,
	output mcpit_pkg::out_word_t result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data
);
	import mcpit_pkg::*;

	cmd_chan_t  cmd_chan;
	logic       cmd_pop;
	logic [7:0] min_interval;
	logic       out_room;
	logic       out_push;
	out_word_t  out_word;

	mcpit_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.item         (item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.min_interval (min_interval),
		.cmd_chan     (cmd_chan),
		.cmd_pop      (cmd_pop)
	);

	mcpit_back #(.NUM_CHANNELS(NUM_CHANNELS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.min_interval (min_interval),
		.cmd_chan     (cmd_chan),
		.cmd_pop      (cmd_pop),
		.out_room     (out_room),
		.out_push     (out_push),
		.out_word     (out_word)
	);

	mcpit_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (out_push),
		.wdata  (out_word),
		.room   (out_room),
		.empty  (empty),
		.pop    (pop),
		.rdata  (result)
	);

endmodule

// ===== design/mcpit_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpit_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcpit_ram #(
	parameter int W = 8,
	parameter int D = 8
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  logic [W-1:0]                      wdata,
	input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic [W-1:0]                      rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/mcpit_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpit_front
// Input side: config registers, word classification and a two-entry
// command queue toward the back end.
// ----------------------------------------------------------------------------
module mcpit_front #(
	parameter int NUM_CHANNELS = mcpit_pkg::NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  mcpit_pkg::in_word_t  item,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_index,
	input  logic [7:0]           cfg_data,
	output logic [7:0]           min_interval,
	output mcpit_pkg::cmd_chan_t cmd_chan,
	input  logic                 cmd_pop
);
	import mcpit_pkg::*;

	logic [7:0] min_interval_q;
	logic [2:0] legacy_channel_q;
	cmd_t       q_mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       cmd_new;
	logic       keep;
	logic       accept;
	logic       do_pop;

	assign cfg_ready    = 1'b1;
	assign min_interval = min_interval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q   <= MIN_IVL_RESET;
			legacy_channel_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MIN_INTERVAL:   min_interval_q   <= cfg_data;
				CFG_LEGACY_CHANNEL: legacy_channel_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cmd_new.ivl  = item.max_ivl;
		cmd_new.link = item.link_up;
		cmd_new.op   = OP_TICK;
		cmd_new.ch   = '0;
		keep         = 1'b0;
		case (item.mode)
			MODE_TICK: begin
				keep = 1'b1;
			end
			MODE_LEGACY_SET: begin
				cmd_new.op = OP_SET;
				cmd_new.ch = CH_FIELD_W'(legacy_channel_q);
				keep       = 9'(legacy_channel_q) < 9'(NUM_CHANNELS);
			end
			MODE_SET: begin
				cmd_new.op = OP_SET;
				cmd_new.ch = CH_FIELD_W'(item.service);
				keep       = 9'(item.service) < 9'(NUM_CHANNELS);
			end
			MODE_REQUEST: begin
				cmd_new.op = OP_REQ;
				cmd_new.ch = CH_FIELD_W'(item.service);
				keep       = 9'(item.service) < 9'(NUM_CHANNELS);
			end
			default: ;
		endcase
	end

	assign full   = (count_q == 2'd2);
	assign accept = push && !full && keep;
	assign do_pop = cmd_pop && (count_q != 2'd0);

	assign cmd_chan.valid = (count_q != 2'd0);
	assign cmd_chan.cmd   = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			q_mem_q[wr_ptr_q] <= cmd_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + 2'(accept) - 2'(do_pop);
		end
	end

endmodule

// ===== design/mcpit_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpit_back
// Command engine: holds per-channel counters and intervals in RAM and
// walks the channels one per cycle on a minute tick while running.
// ----------------------------------------------------------------------------
module mcpit_back #(
	parameter int NUM_CHANNELS = mcpit_pkg::NUM_CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           min_interval,
	input  mcpit_pkg::cmd_chan_t cmd_chan,
	output logic                 cmd_pop,
	input  logic                 out_room,
	output logic                 out_push,
	output mcpit_pkg::out_word_t out_word
);
	import mcpit_pkg::*;

	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int N_W   = $clog2(MAX_RESULTS + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_REQ   = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	localparam logic [CH_W-1:0] LAST_CH = CH_W'(NUM_CHANNELS - 1);

	logic [1:0]              state_q;
	logic                    running_q;
	logic [NUM_CHANNELS-1:0] cnt_vld_q;
	logic [NUM_CHANNELS-1:0] ivl_vld_q;
	logic [CH_W-1:0]         idx_q;
	logic [N_W-1:0]          n_q;
	logic                    link_q;
	logic                    pend_vld_q;
	logic [2:0]              pend_ch_q;

	logic [CH_W-1:0] cmd_ch;
	logic [CH_W-1:0] rd_addr;
	logic [7:0]      cnt_rdata;
	logic [15:0]     ivl_rdata;
	logic            cnt_we;
	logic [CH_W-1:0] cnt_waddr;
	logic [7:0]      cnt_wdata;
	logic            ivl_we;
	logic [7:0]      cnt_cur;
	logic [7:0]      max_cur;
	logic [7:0]      min_cur;
	logic [7:0]      cnt_inc;
	logic [5:0]      idx_wide;
	logic [2:0]      idx_ch;
	logic            walk_fire;
	logic            req_fire;
	logic            start;

	assign cmd_ch   = cmd_chan.cmd.ch[CH_W-1:0];
	assign start    = (state_q == ST_IDLE) && cmd_chan.valid && out_room;
	assign cmd_pop  = start;
	assign idx_wide = 6'(idx_q);
	assign idx_ch   = idx_wide[2:0];

	assign cnt_cur = cnt_vld_q[idx_q] ? cnt_rdata : 8'd0;
	assign max_cur = ivl_vld_q[idx_q] ? ivl_rdata[15:8] : 8'd0;
	assign min_cur = ivl_vld_q[idx_q] ? ivl_rdata[7:0] : 8'd0;
	assign cnt_inc = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 8'd1;

	assign walk_fire = (max_cur != 8'd0) && (cnt_inc >= max_cur) && (cnt_inc >= min_cur)
		&& link_q && (n_q < N_W'(MAX_RESULTS));
	assign req_fire  = (cnt_cur >= min_cur) && link_q;

	always_comb begin
		rd_addr = '0;
		case (state_q)
			ST_IDLE: rd_addr = (cmd_chan.cmd.op == OP_REQ) ? cmd_ch : '0;
			ST_WALK: rd_addr = idx_q + CH_W'(1);
			default: rd_addr = '0;
		endcase
	end

	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = idx_q;
		cnt_wdata = 8'd0;
		out_push  = 1'b0;
		out_word  = '0;
		ivl_we    = start && (cmd_chan.cmd.op == OP_SET);
		case (state_q)
			ST_WALK: begin
				if (max_cur != 8'd0) begin
					cnt_we    = 1'b1;
					cnt_wdata = walk_fire ? 8'd0 : cnt_inc;
				end
				if (walk_fire && pend_vld_q) begin
					out_push              = 1'b1;
					out_word.poll_channel = pend_ch_q;
					out_word.last         = 1'b0;
				end
			end
			ST_REQ: begin
				if (req_fire) begin
					cnt_we                = 1'b1;
					out_push              = 1'b1;
					out_word.poll_channel = idx_ch;
					out_word.last         = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (pend_vld_q) begin
					out_push              = 1'b1;
					out_word.poll_channel = pend_ch_q;
					out_word.last         = 1'b1;
				end
			end
			default: ;
		endcase
	end

	mcpit_ram #(.W(8), .D(NUM_CHANNELS)) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.raddr (rd_addr),
		.rdata (cnt_rdata)
	);

	mcpit_ram #(.W(16), .D(NUM_CHANNELS)) u_ivl_ram (
		.clk   (clk),
		.we    (ivl_we),
		.waddr (cmd_ch),
		.wdata ({cmd_chan.cmd.ivl, min_interval}),
		.raddr (rd_addr),
		.rdata (ivl_rdata)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_WALK && walk_fire) begin
			pend_ch_q <= idx_ch;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			running_q  <= 1'b0;
			cnt_vld_q  <= '0;
			ivl_vld_q  <= '0;
			idx_q      <= '0;
			n_q        <= '0;
			link_q     <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			if (cnt_we) begin
				cnt_vld_q[cnt_waddr] <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						idx_q      <= '0;
						n_q        <= '0;
						pend_vld_q <= 1'b0;
						link_q     <= cmd_chan.cmd.link;
						case (cmd_chan.cmd.op)
							OP_TICK: begin
								if (running_q) begin
									state_q <= ST_WALK;
								end
							end
							OP_SET: begin
								ivl_vld_q[cmd_ch] <= 1'b1;
								if (cmd_chan.cmd.ivl == 8'd0) begin
									running_q <= 1'b0;
								end else if (!running_q) begin
									running_q <= 1'b1;
									cnt_vld_q <= '0;
								end
							end
							OP_REQ: begin
								idx_q   <= cmd_ch;
								state_q <= ST_REQ;
							end
							default: ;
						endcase
					end
				end
				ST_WALK: begin
					if (walk_fire) begin
						n_q        <= n_q + N_W'(1);
						pend_vld_q <= 1'b1;
					end
					if (idx_q == LAST_CH) begin
						state_q <= ST_FLUSH;
					end else begin
						idx_q <= idx_q + CH_W'(1);
					end
				end
				ST_REQ: begin
					state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					pend_vld_q <= 1'b0;
					state_q    <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== design/mcpit_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpit_out_fifo
// Result queue; reports room for one full burst of tick results.
// ----------------------------------------------------------------------------
module mcpit_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  mcpit_pkg::out_word_t wdata,
	output logic                 room,
	output logic                 empty,
	input  logic                 pop,
	output mcpit_pkg::out_word_t rdata
);
	import mcpit_pkg::*;

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	out_word_t        mem_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign empty  = (count_q == '0);
	assign do_pop = pop && !empty;
	assign rdata  = mem_q[rd_ptr_q];
	assign room   = count_q <= CNT_W'(OUT_DEPTH - MAX_RESULTS);

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(wr) - CNT_W'(do_pop);
		end
	end

endmodule

// ===== design/mcpit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcpit_checker
// Port-level checks for the poll interval timer, bound to the top level.
// ----------------------------------------------------------------------------
module mcpit_checker #(
	parameter int NUM_CHANNELS = mcpit_pkg::NUM_CHANNELS_DEF
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 push,
	input logic                 full,
	input mcpit_pkg::in_word_t  item,
	input logic                 empty,
	input logic                 pop,
	input mcpit_pkg::out_word_t result
);
	import mcpit_pkg::*;

	a_reset_empty: assert property (@(posedge clk) !arst_n |=> empty && !full)
		else $error("queues not empty in reset");

	a_full_needs_push: assert property (@(posedge clk) disable iff (!arst_n)
		!full && !push |=> !full)
		else $error("full rose without a pushed word");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("waiting result changed or vanished");

	a_channel_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (NUM_CHANNELS > 7) || (32'(result.poll_channel) < NUM_CHANNELS))
		else $error("poll for a channel out of range");

	a_item_known: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |-> !$isunknown(item.mode))
		else $error("pushed word with unknown mode");

endmodule

bind multi_channel_poll_interval_timer mcpit_checker #(.NUM_CHANNELS(NUM_CHANNELS)) u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.push   (push),
	.full   (full),
	.item   (item),
	.empty  (empty),
	.pop    (pop),
	.result (result)
);
